/* rtl/core/u8v_pkg.sv */
// shared types and constants for the utf-8 stream validator
package u8v_pkg;

  localparam longint unsigned MaxStringBytes = 64'd16777216;
  localparam int OffsetW = 24;
  localparam longint unsigned OffsetMax = 64'hFFFFFF;
  localparam logic [OffsetW-1:0] OffsetCap =
    ((MaxStringBytes - 64'd1) < OffsetMax) ? OffsetW'(MaxStringBytes - 64'd1)
                                           : OffsetW'(OffsetMax);

  typedef enum logic [2:0] {
    StValid     = 3'd0,
    StBadLead   = 3'd1,
    StTruncated = 3'd2,
    StBadCont   = 3'd3,
    StInvalid   = 3'd4
  } u8v_status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } u8v_item_t;

  typedef struct packed {
    logic               done;
    u8v_status_e        status;
    logic [OffsetW-1:0] offset;
  } u8v_result_t;

endpackage

/* rtl/core/u8v_step.sv */
// per-byte utf-8 decode, string state and status generation
module u8v_step import u8v_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  u8v_item_t   item_i,
  output u8v_result_t result_o
);

  logic [OffsetW-1:0] byte_count_q, byte_count_d;
  logic [OffsetW-1:0] lead_pos_q, lead_pos_d;
  logic [20:0]        partial_q, partial_d;
  logic [1:0]         need_q, need_d;
  logic [1:0]         extra_q, extra_d;
  logic               err_q, err_d;
  u8v_status_e        err_status_q, err_status_d;
  logic [OffsetW-1:0] err_off_q, err_off_d;
  logic               cont_q, cont_d;

  logic [7:0]         c;
  logic               bad_seq;

  assign c = item_i.data;

  always_comb begin
    byte_count_d = byte_count_q;
    lead_pos_d   = lead_pos_q;
    partial_d    = partial_q;
    need_d       = need_q;
    extra_d      = extra_q;
    err_d        = err_q;
    err_status_d = err_status_q;
    err_off_d    = err_off_q;
    cont_d       = cont_q;
    result_o     = '{done: 1'b0, status: StValid, offset: '0};
    bad_seq      = 1'b0;

    if (!item_i.empty) begin
      if (!err_q) begin
        if (need_q == 2'd0) begin
          if (c <= 8'h7F) begin
            // plain ascii
          end else if (c >= 8'hC2 && c <= 8'hDF) begin
            partial_d  = {16'd0, c[4:0]};
            need_d     = 2'd1;
            extra_d    = 2'd1;
            lead_pos_d = byte_count_q;
            cont_d     = 1'b0;
          end else if (c >= 8'hE0 && c <= 8'hEF) begin
            partial_d  = {17'd0, c[3:0]};
            need_d     = 2'd2;
            extra_d    = 2'd2;
            lead_pos_d = byte_count_q;
            cont_d     = 1'b0;
          end else if (c >= 8'hF0 && c <= 8'hF4) begin
            partial_d  = {18'd0, c[2:0]};
            need_d     = 2'd3;
            extra_d    = 2'd3;
            lead_pos_d = byte_count_q;
            cont_d     = 1'b0;
          end else begin
            err_d        = 1'b1;
            err_status_d = StBadLead;
            err_off_d    = byte_count_q;
            need_d       = 2'd0;
            cont_d       = 1'b0;
          end
        end else begin
          if (!cont_q) begin
            if (c[7:6] != 2'b10) begin
              cont_d       = 1'b1;
              err_status_d = StBadCont;
              err_off_d    = byte_count_q;
            end else begin
              partial_d = {partial_q[14:0], c[5:0]};
            end
          end
          need_d = need_q - 2'd1;
          if (need_q == 2'd1) begin
            // sequence complete
            bad_seq = (extra_q == 2'd2 && partial_d < 21'h800) ||
                      (extra_q == 2'd3 && partial_d < 21'h10000) ||
                      (partial_d > 21'h10FFFF) ||
                      (partial_d >= 21'hD800 && partial_d <= 21'hDFFF);
            if (cont_d) begin
              err_d        = 1'b1;
              err_status_d = StBadCont;
              cont_d       = 1'b0;
            end else if (bad_seq) begin
              err_d        = 1'b1;
              err_status_d = StInvalid;
              err_off_d    = lead_pos_q;
              cont_d       = 1'b0;
            end
          end
        end
      end
      byte_count_d = (byte_count_q < OffsetCap) ? byte_count_q + OffsetW'(1) : OffsetCap;
    end

    if (item_i.empty || item_i.last) begin
      result_o.done = 1'b1;
      if (err_d) begin
        result_o.status = err_status_d;
        result_o.offset = err_off_d;
      end else if (need_d != 2'd0) begin
        result_o.status = StTruncated;
        result_o.offset = lead_pos_d;
      end
      byte_count_d = '0;
      lead_pos_d   = '0;
      partial_d    = '0;
      need_d       = '0;
      extra_d      = '0;
      err_d        = 1'b0;
      err_status_d = StValid;
      err_off_d    = '0;
      cont_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      lead_pos_q   <= '0;
      partial_q    <= '0;
      need_q       <= '0;
      extra_q      <= '0;
      err_q        <= 1'b0;
      err_status_q <= StValid;
      err_off_q    <= '0;
      cont_q       <= 1'b0;
    end else if (step_i) begin
      byte_count_q <= byte_count_d;
      lead_pos_q   <= lead_pos_d;
      partial_q    <= partial_d;
      need_q       <= need_d;
      extra_q      <= extra_d;
      err_q        <= err_d;
      err_status_q <= err_status_d;
      err_off_q    <= err_off_d;
      cont_q       <= cont_d;
    end
  end

endmodule

/* rtl/core/utf8_stream_validator_top.sv */
// status path: input register, decode stage, status register, then m_axis
// throughput: one byte per cycle, set by the single decode stage between the
// input and status registers, but a last byte waits while m_axis holds a status
// reset: rst_ni low clears the string state and both valid flags, no status pending
module utf8_stream_validator_top import u8v_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tlast,  // last_byte
  input  logic [0:0]  s_axis_tuser,  // empty_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // status[2:0], error_offset[26:3], zero pad
);

  logic        in_valid_q;
  u8v_item_t   item_q;
  logic        out_valid_q;
  logic [31:0] out_data_q;
  u8v_result_t res;
  logic        out_free;
  logic        fire;

  u8v_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .item_i   (item_q),
    .result_o (res)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!res.done || out_free);
  assign s_axis_tready = !in_valid_q || fire;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= fire && res.done;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= '{data: s_axis_tdata, last: s_axis_tlast, empty: s_axis_tuser[0]};
    end
    if (fire && res.done) begin
      out_data_q <= {5'd0, res.offset, res.status};
    end
  end

endmodule
